// File: rtl/pdps_pkg.sv
// Package for the partitioned dirty page set: sizes, key mixing constants,
// result codes and the command/status structs between controller and datapath.
// No dependencies.
package pdps_pkg;

   // Default geometry
   localparam int unsigned PARTITIONS_DEF = 8;
   localparam int unsigned SLOTS_DEF      = 256;

   // Key layout and mixing
   localparam int unsigned KEY_W      = 64;
   localparam int unsigned HALF_W     = 32;
   localparam int unsigned SLOT_SHIFT = 7;
   localparam logic [KEY_W-1:0] MIX_MULT = 64'h9E37_79B9_7F4A_7C15;

   // mark_status codes
   localparam logic [1:0] ST_CHECK    = 2'd0;
   localparam logic [1:0] ST_INSERTED = 2'd1;
   localparam logic [1:0] ST_PRESENT  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // Multiplier operand selection
   localparam logic [1:0] MUL_LL = 2'd0;   // key low  x mult low
   localparam logic [1:0] MUL_HL = 2'd1;   // key high x mult low
   localparam logic [1:0] MUL_LH = 2'd2;   // key low  x mult high

   // Store update at the end of a probe
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_INSERT  = 2'd1;
   localparam logic [1:0] ACT_SETFULL = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic       clear;      // clearing sweep step
      logic       capture;    // latch the request
      logic [1:0] mul_sel;
      logic       acc_init;   // take the low x low product
      logic       acc_add;    // add a cross product into the high half
      logic       mix;        // last cross product, fold halves
      logic       mod_step;   // partition / slot reduction step
      logic       issue;      // first slot read
      logic       advance;    // step to the next slot
      logic       finish;     // result transfer and store update
      logic [1:0] act;
      logic       rsp_dirty;
      logic [1:0] rsp_status;
   } pdps_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic mod_done;
      logic is_mark;
      logic hit;
      logic empty;
      logic full;
      logic at_ceiling;
      logic exhausted;
   } pdps_status_type;

endpackage

// File: rtl/pdps_dp.sv
// Datapath of the partitioned dirty page set: key mixing with one shared
// 32x32 multiplier, partition/slot reduction, slot and count memories.
// Depends on pdps_pkg.
module pdps_dp #(
   parameter int unsigned PARTITIONS          = pdps_pkg::PARTITIONS_DEF,
   parameter int unsigned SLOTS_PER_PARTITION = pdps_pkg::SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pdps_pkg::pdps_cmd_type cmd,
   output pdps_pkg::pdps_status_type status,
   input  logic                   req_cmd,
   input  logic [31:0]            req_relation_id,
   input  logic [31:0]            req_block_number,
   output logic                   rsp_valid,
   output logic                   rsp_dirty,
   output logic [1:0]             rsp_mark_status
);
   import pdps_pkg::*;

   localparam int unsigned PART_W   = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam int unsigned SLOT_W   = $clog2(SLOTS_PER_PARTITION);
   localparam int unsigned ADDR_W   = PART_W + SLOT_W;
   localparam int unsigned MAX_LOAD = (SLOTS_PER_PARTITION * 3) / 4;
   localparam int unsigned CNT_W    = $clog2(MAX_LOAD + 1);
   localparam bit MOD_POW2 = ((PARTITIONS & (PARTITIONS - 1)) == 0) &&
                             ((SLOTS_PER_PARTITION & (SLOTS_PER_PARTITION - 1)) == 0);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_PARTITION - 1);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_LOAD);

   // Request and mixing registers
   logic              is_mark_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [KEY_W-1:0]  mul_ff;
   logic [KEY_W-1:0]  mul_in;
   logic [HALF_W-1:0] mul_a;
   logic [HALF_W-1:0] mul_b;
   logic [HALF_W-1:0] acc_lo_ff;
   logic [HALF_W-1:0] acc_hi_ff;
   logic [HALF_W-1:0] mix_hi;
   logic [KEY_W-1:0]  mixed_in;
   logic [KEY_W-1:0]  mixed_ff;

   // Probe registers
   logic [PART_W-1:0] part_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_next;
   logic [SLOT_W-1:0] probe_cnt_ff;
   logic [PART_W-1:0] part_new;
   logic [SLOT_W-1:0] slot_new;
   logic              mod_done;

   // Memories
   logic [KEY_W-1:0]  slot_mem [2**ADDR_W];
   logic [CNT_W:0]    cnt_mem  [2**PART_W];
   logic [KEY_W-1:0]  slot_rd_ff;
   logic [CNT_W:0]    cnt_rd_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] sweep_ff;
   logic [CNT_W-1:0]  cnt_cur;
   logic              full_cur;

   // Result registers
   logic       rsp_valid_ff;
   logic       rsp_dirty_ff;
   logic [1:0] rsp_status_ff;

   // Shared multiplier operand select
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_HL: begin
            mul_a = key_ff[KEY_W-1:HALF_W];
            mul_b = MIX_MULT[HALF_W-1:0];
         end
         MUL_LH: begin
            mul_a = key_ff[HALF_W-1:0];
            mul_b = MIX_MULT[KEY_W-1:HALF_W];
         end
         default: begin
            mul_a = key_ff[HALF_W-1:0];
            mul_b = MIX_MULT[HALF_W-1:0];
         end
      endcase
   end

   assign mul_in   = KEY_W'(mul_a) * KEY_W'(mul_b);
   assign mix_hi   = acc_hi_ff + mul_ff[HALF_W-1:0];
   assign mixed_in = {mix_hi, acc_lo_ff ^ mix_hi};

   // Request capture, product accumulation, mixed key
   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      if (cmd.capture) begin
         is_mark_ff <= req_cmd;
         key_ff     <= {req_relation_id, req_block_number};
      end
      if (cmd.acc_init) begin
         acc_lo_ff <= mul_ff[HALF_W-1:0];
         acc_hi_ff <= mul_ff[KEY_W-1:HALF_W];
      end
      if (cmd.acc_add) begin
         acc_hi_ff <= acc_hi_ff + mul_ff[HALF_W-1:0];
      end
      if (cmd.mix) begin
         mixed_ff <= mixed_in;
      end
   end

   // Partition and first slot from the mixed key
   generate
      if (MOD_POW2) begin : g_mask
         assign part_new = mixed_ff[PART_W-1:0] & PART_W'(PARTITIONS - 1);
         assign slot_new = mixed_ff[SLOT_SHIFT +: SLOT_W];
         assign mod_done = 1'b1;
      end else begin : g_rem
         // Remainder by constant, eight bits per cycle from the top
         localparam int unsigned PM_W = $clog2(PARTITIONS + 1) + 1;
         localparam int unsigned SM_W = $clog2(SLOTS_PER_PARTITION) + 1;
         localparam logic [PM_W-1:0] PMOD = PM_W'(PARTITIONS);
         localparam logic [SM_W-1:0] SMOD = SM_W'(SLOTS_PER_PARTITION);

         logic [KEY_W-1:0] mod_sh_ff;
         logic [2:0]       mod_cnt_ff;
         logic [PM_W-1:0]  rem_p_ff;
         logic [SM_W-1:0]  rem_s_ff;
         logic [PM_W-1:0]  rem_p_in;
         logic [SM_W-1:0]  rem_s_in;
         logic             last_byte;

         assign last_byte = (mod_cnt_ff == 3'd7);

         always_comb begin
            logic [PM_W-1:0] tp;
            logic [SM_W-1:0] ts;
            tp = rem_p_ff;
            ts = rem_s_ff;
            for (int i = 7; i >= 0; i--) begin
               tp = {tp[PM_W-2:0], mod_sh_ff[KEY_W-8+i]};
               if (tp >= PMOD) tp = tp - PMOD;
               // slot index drops the low SLOT_SHIFT bits of the key
               if (!(last_byte && (i < 7))) begin
                  ts = {ts[SM_W-2:0], mod_sh_ff[KEY_W-8+i]};
                  if (ts >= SMOD) ts = ts - SMOD;
               end
            end
            rem_p_in = tp;
            rem_s_in = ts;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               mod_cnt_ff <= '0;
            end else if (cmd.mix) begin
               mod_cnt_ff <= '0;
            end else if (cmd.mod_step) begin
               mod_cnt_ff <= mod_cnt_ff + 3'd1;
            end
            if (cmd.mix) begin
               mod_sh_ff <= mixed_in;
               rem_p_ff  <= '0;
               rem_s_ff  <= '0;
            end else if (cmd.mod_step) begin
               mod_sh_ff <= {mod_sh_ff[KEY_W-9:0], 8'd0};
               rem_p_ff  <= rem_p_in;
               rem_s_ff  <= rem_s_in;
            end
         end

         assign part_new = rem_p_in[PART_W-1:0];
         assign slot_new = rem_s_in[SLOT_W-1:0];
         assign mod_done = last_byte;
      end
   endgenerate

   // Probe position
   assign slot_next = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.mod_step && mod_done) begin
         part_ff <= part_new;
         slot_ff <= slot_new;
      end else if (cmd.advance) begin
         slot_ff <= slot_next;
      end
      if (cmd.issue) begin
         probe_cnt_ff <= '0;
      end else if (cmd.advance) begin
         probe_cnt_ff <= probe_cnt_ff + SLOT_W'(1);
      end
   end

   // Clearing sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.clear) begin
         sweep_ff <= sweep_ff + ADDR_W'(1);
      end
   end

   assign rd_addr  = cmd.advance ? {part_ff, slot_next} : {part_ff, slot_ff};
   assign wr_addr  = {part_ff, slot_ff};
   assign cnt_cur  = cnt_rd_ff[CNT_W-1:0];
   assign full_cur = cnt_rd_ff[CNT_W];

   // Slot memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         slot_mem[sweep_ff] <= '0;
      end else if (cmd.finish && (cmd.act == ACT_INSERT)) begin
         slot_mem[wr_addr] <= key_ff;
      end
      slot_rd_ff <= slot_mem[rd_addr];
   end

   // Per-partition fill count and sticky full flag
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         cnt_mem[sweep_ff[PART_W-1:0]] <= '0;
      end else if (cmd.finish && (cmd.act == ACT_INSERT)) begin
         cnt_mem[part_ff] <= {1'b0, cnt_cur + CNT_W'(1)};
      end else if (cmd.finish && (cmd.act == ACT_SETFULL)) begin
         cnt_mem[part_ff] <= {1'b1, cnt_cur};
      end
      cnt_rd_ff <= cnt_mem[part_ff];
   end

   // Status to the controller
   assign status.clear_done = (sweep_ff == '1);
   assign status.mod_done   = mod_done;
   assign status.is_mark    = is_mark_ff;
   assign status.hit        = (slot_rd_ff == key_ff);
   assign status.empty      = (slot_rd_ff == '0);
   assign status.full       = full_cur;
   assign status.at_ceiling = (cnt_cur >= CNT_MAX);
   assign status.exhausted  = (probe_cnt_ff == SLOT_LAST);

   // Result register, one strobed transfer per item
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
      if (cmd.finish) begin
         rsp_dirty_ff  <= cmd.rsp_dirty;
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dirty       = rsp_dirty_ff;
   assign rsp_mark_status = rsp_status_ff;

endmodule

// File: rtl/pdps_ctrl.sv
// Controller of the partitioned dirty page set: sequences clearing, key
// mixing, reduction and the linear probe, and decides each result.
// Depends on pdps_pkg.
module pdps_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  pdps_pkg::pdps_status_type status,
   output pdps_pkg::pdps_cmd_type    cmd
);
   import pdps_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MUL0  = 4'd2;
   localparam logic [3:0] S_MUL1  = 4'd3;
   localparam logic [3:0] S_MUL2  = 4'd4;
   localparam logic [3:0] S_MIX   = 4'd5;
   localparam logic [3:0] S_MOD   = 4'd6;
   localparam logic [3:0] S_ISSUE = 4'd7;
   localparam logic [3:0] S_PROBE = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign busy = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_LL;
      cmd.act     = ACT_NONE;
      cmd.rsp_status = ST_CHECK;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL0;
            end
         end
         S_MUL0: begin
            cmd.mul_sel = MUL_LL;
            state_in    = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_sel  = MUL_HL;
            cmd.acc_init = 1'b1;
            state_in     = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_sel = MUL_LH;
            cmd.acc_add = 1'b1;
            state_in    = S_MIX;
         end
         S_MIX: begin
            cmd.mix  = 1'b1;
            state_in = S_MOD;
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_done) state_in = S_ISSUE;
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
            state_in  = S_PROBE;
         end
         S_PROBE: begin
            // Order matters: full flag, then match, then empty slot
            priority if (status.full) begin
               cmd.finish     = 1'b1;
               cmd.rsp_dirty  = !status.is_mark;
               cmd.rsp_status = status.is_mark ? ST_FULL : ST_CHECK;
            end else if (status.hit) begin
               cmd.finish     = 1'b1;
               cmd.rsp_dirty  = !status.is_mark;
               cmd.rsp_status = status.is_mark ? ST_PRESENT : ST_CHECK;
            end else if (status.empty) begin
               cmd.finish = 1'b1;
               if (status.is_mark && status.at_ceiling) begin
                  cmd.act        = ACT_SETFULL;
                  cmd.rsp_status = ST_FULL;
               end else if (status.is_mark) begin
                  cmd.act        = ACT_INSERT;
                  cmd.rsp_status = ST_INSERTED;
               end
            end else if (status.exhausted) begin
               cmd.finish = 1'b1;
               if (status.is_mark) begin
                  cmd.act        = ACT_SETFULL;
                  cmd.rsp_status = ST_FULL;
               end else begin
                  cmd.rsp_dirty = 1'b1;
               end
            end else begin
               cmd.advance = 1'b1;
            end
            if (cmd.finish) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register, reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/partitioned_dirty_page_set_core.sv
// Partitioned dirty page set. One item at a time: a new transfer is taken only while busy
// is low. The probe visits 1 .. SLOTS_PER_PARTITION slots one by one, as set by the single
// slot-memory read port. Non power-of-two sizes add a remainder unit (8 key bits a cycle).
// busy drops with the result strobe; the receiver cannot stall. After reset a clearing
// sweep of all 2**(PART_W+SLOT_W) slot entries (2048 by default) runs with busy high.
module partitioned_dirty_page_set_core #(
   parameter int unsigned PARTITIONS          = pdps_pkg::PARTITIONS_DEF,
   parameter int unsigned SLOTS_PER_PARTITION = pdps_pkg::SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [31:0] req_relation_id,
   input  logic [31:0] req_block_number,
   output logic        rsp_valid,
   output logic        rsp_dirty,
   output logic [1:0]  rsp_mark_status
);
   import pdps_pkg::*;

   pdps_cmd_type    cmd;
   pdps_status_type status;

   // Sequencer
   pdps_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Mixing, probing and storage
   pdps_dp #(
      .PARTITIONS          (PARTITIONS),
      .SLOTS_PER_PARTITION (SLOTS_PER_PARTITION)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_cmd          (req_cmd),
      .req_relation_id  (req_relation_id),
      .req_block_number (req_block_number),
      .rsp_valid        (rsp_valid),
      .rsp_dirty        (rsp_dirty),
      .rsp_mark_status  (rsp_mark_status)
   );

endmodule
